// File: hw/rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg: shared types and constants of the watchdog timer
// Control register bit positions, item codes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package wdt_pkg;

  // Configuration register widths and reset values.
  localparam int unsigned CpuFreqW     = 32;
  localparam int unsigned WdtFreqW     = 20;
  localparam logic [CpuFreqW-1:0] CpuFreqReset = 32'd16000000;
  localparam logic [WdtFreqW-1:0] WdtFreqReset = 20'd128000;

  // Default parameter values.
  localparam int unsigned CountWidthDef   = 52;
  localparam int unsigned UnlockCyclesDef = 4;

  // Timeout length arithmetic: cpu_freq << (p + 11), p at most 9.
  localparam int unsigned PrescaleMax = 9;
  localparam int unsigned ShiftBase   = 11;
  localparam int unsigned DividendW   = CpuFreqW + PrescaleMax + ShiftBase;
  localparam int unsigned DivCntW     = $clog2(DividendW);

  // Control register bit positions.
  localparam int unsigned BitIf = 7;
  localparam int unsigned BitIe = 6;
  localparam int unsigned BitP3 = 5;
  localparam int unsigned BitCe = 4;
  localparam int unsigned BitRe = 3;
  localparam logic [7:0] PrescaleMask = 8'h27;

  // Item codes.
  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_WRITE = 3'd1,
    FUNC_KICK  = 3'd2,
    FUNC_ACK   = 3'd3,
    FUNC_RESET = 3'd4
  } func_e;

  // What an item does to the timer.
  typedef enum logic [1:0] {
    ACT_KEEP,
    ACT_DEC,
    ACT_STOP,
    ACT_RESTART
  } timer_act_e;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_last;
  } wdt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } wdt_status_t;

endpackage

// File: hw/rtl/wdt_ctrl.sv
// ----------------------------------------------------------------------------
// wdt_ctrl: sequencing controller of the watchdog timer
// Accepts words when the datapath can take them and steps the timeout
// divider one quotient bit per cycle after a timer restart.
// ----------------------------------------------------------------------------
module wdt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  wdt_pkg::wdt_status_t status_i,
  output wdt_pkg::wdt_cmd_t    cmd_o
);
  import wdt_pkg::*;

  ctrl_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q;

  // State register and divide step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_o.accept) begin
        cnt_q <= '0;
      end else if (cmd_o.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    s_ready_o       = 1'b0;
    cmd_o.accept    = 1'b0;
    cmd_o.div_step  = 1'b0;
    cmd_o.div_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o    = status_i.out_free;
        cmd_o.accept = s_valid_i && status_i.out_free;
        if (cmd_o.accept && status_i.need_div) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DivCntW'(DividendW - 1)) begin
          cmd_o.div_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/wdt_datapath.sv
// ----------------------------------------------------------------------------
// wdt_datapath: control register, timer and timeout divider
// Decodes each word against the control register, counts the timer down,
// holds the result word and computes timeout lengths by restoring division.
// ----------------------------------------------------------------------------
module wdt_datapath #(
  parameter int unsigned CountWidth   = wdt_pkg::CountWidthDef,
  parameter int unsigned UnlockCycles = wdt_pkg::UnlockCyclesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wdt_pkg::wdt_cmd_t               cmd_i,
  output wdt_pkg::wdt_status_t            status_o,
  input  logic [wdt_pkg::CpuFreqW-1:0]    cpu_freq_i,
  input  logic [wdt_pkg::WdtFreqW-1:0]    wdt_freq_i,
  input  logic [2:0]                      func_i,
  input  logic [7:0]                      write_value_i,
  input  logic                            reset_flag_set_i,
  input  logic                            reset_by_watchdog_i,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [7:0]                      control_value_o,
  output logic                            irq_raise_o,
  output logic                            reset_request_o
);
  import wdt_pkg::*;

  localparam int unsigned UnlockW = $clog2(UnlockCycles + 1);
  localparam int unsigned ExtW    = (CountWidth > DividendW) ? CountWidth : DividendW;

  // Architectural state.
  logic [7:0]            ctrl_q, ctrl_d;
  logic                  running_q;
  logic [CountWidth-1:0] count_q;
  logic [UnlockW-1:0]    unlock_q, unlock_d;

  // Result word.
  logic       out_valid_q;
  logic [7:0] out_ctrl_q;
  logic       out_irq_q, out_irq_d;
  logic       out_rst_q, out_rst_d;

  // Divider.
  logic [DividendW-1:0] quo_q, quo_d;
  logic [WdtFreqW-1:0]  rem_q, rem_d;
  logic [WdtFreqW-1:0]  divisor_q;
  logic [WdtFreqW:0]    rem_shift;
  logic [WdtFreqW:0]    rem_diff;
  logic                 quo_bit;
  logic [ExtW-1:0]      quo_ext;
  logic [CountWidth-1:0] len;

  func_e      func;
  timer_act_e act;
  logic [7:0] v;
  logic       unlocked;
  logic [3:0] presc;
  logic       len_zero;

  assign func     = func_e'(func_i);
  assign unlocked = (unlock_q != '0);

  // Item decode: next control register, unlock window and timer action.
  always_comb begin
    ctrl_d    = ctrl_q;
    unlock_d  = unlock_q;
    act       = ACT_KEEP;
    out_irq_d = 1'b0;
    out_rst_d = 1'b0;
    v         = write_value_i;
    case (func)
      FUNC_TICK: begin
        if (unlocked) begin
          unlock_d = unlock_q - 1'b1;
          if (unlock_q == UnlockW'(1)) begin
            ctrl_d[BitCe] = 1'b0;
          end
        end
        if (running_q) begin
          if (count_q == CountWidth'(1)) begin
            act = ACT_STOP;
            if (ctrl_d[BitIe] && !ctrl_d[BitIf]) begin
              ctrl_d[BitIf] = 1'b1;
              out_irq_d     = 1'b1;
              act           = ACT_RESTART;
            end else if (ctrl_d[BitRe] || ctrl_d[BitIf]) begin
              out_rst_d = 1'b1;
            end
          end else begin
            act = ACT_DEC;
          end
        end
      end
      FUNC_WRITE: begin
        if (reset_flag_set_i) begin
          v[BitRe] = 1'b1;
        end
        if (unlocked) begin
          v[BitCe] = 1'b1;
        end else begin
          v = (v & ~PrescaleMask) | (ctrl_q & PrescaleMask);
          if (ctrl_q[BitRe]) begin
            v[BitRe] = 1'b1;
          end
        end
        // Writing one to the interrupt flag clears it, zero keeps it.
        ctrl_d        = v;
        ctrl_d[BitIf] = v[BitIf] ? 1'b0 : ctrl_q[BitIf];
        if (unlocked) begin
          if (((v ^ ctrl_q) & PrescaleMask) != 8'h00) begin
            act = ACT_RESTART;
          end
          if (ctrl_q[BitRe] && !v[BitRe]) begin
            act = ACT_STOP;
          end
        end else if (v[BitCe] && v[BitRe]) begin
          unlock_d = UnlockW'(UnlockCycles);
        end
        // A rising reset or interrupt enable restarts the timer.
        if ((v[BitRe] && !ctrl_q[BitRe]) || (v[BitIe] && !ctrl_q[BitIe])) begin
          act = ACT_RESTART;
        end
      end
      FUNC_KICK: begin
        if (running_q) begin
          act = ACT_RESTART;
        end
      end
      FUNC_ACK: begin
        ctrl_d[BitIf] = 1'b0;
        ctrl_d[BitIe] = 1'b0;
        act           = ACT_RESTART;
      end
      FUNC_RESET: begin
        unlock_d = '0;
        if (reset_by_watchdog_i) begin
          ctrl_d        = 8'h00;
          ctrl_d[BitRe] = 1'b1;
          act           = ACT_RESTART;
        end else begin
          ctrl_d = 8'h00;
          act    = ACT_STOP;
        end
      end
      default: begin
        act = ACT_KEEP;
      end
    endcase
  end

  // A restart needs the divider unless the length is known to be zero.
  assign presc    = {ctrl_d[BitP3], ctrl_d[2:0]};
  assign len_zero = (presc > 4'(PrescaleMax)) || (wdt_freq_i == '0);

  assign status_o.need_div = (act == ACT_RESTART) && !len_zero;
  assign status_o.out_free = !out_valid_q || m_ready_i;

  // Restoring division step: one quotient bit per cycle.
  always_comb begin
    rem_shift = {rem_q, quo_q[DividendW-1]};
    rem_diff  = rem_shift - {1'b0, divisor_q};
    quo_bit   = (rem_shift >= {1'b0, divisor_q});
    rem_d     = quo_bit ? rem_diff[WdtFreqW-1:0] : rem_shift[WdtFreqW-1:0];
    quo_d     = {quo_q[DividendW-2:0], quo_bit};
  end

  // Saturate the quotient to the counter width.
  always_comb begin
    quo_ext = ExtW'(quo_d);
    if (quo_ext > ExtW'({CountWidth{1'b1}})) begin
      len = '1;
    end else begin
      len = quo_ext[CountWidth-1:0];
    end
  end

  // Divider operands, loaded when a word is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      quo_q     <= DividendW'(cpu_freq_i) << (5'(presc) + 5'(ShiftBase));
      rem_q     <= '0;
      divisor_q <= wdt_freq_i;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Control register, unlock window and timer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      unlock_q  <= '0;
      running_q <= 1'b0;
      count_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        ctrl_q   <= ctrl_d;
        unlock_q <= unlock_d;
        case (act)
          ACT_DEC: begin
            count_q <= count_q - 1'b1;
          end
          ACT_STOP, ACT_RESTART: begin
            running_q <= 1'b0;
            count_q   <= '0;
          end
          default: begin
            count_q <= count_q;
          end
        endcase
      end
      if (cmd_i.div_last) begin
        count_q   <= len;
        running_q <= (len != '0);
      end
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.accept) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_ctrl_q <= ctrl_d;
      out_irq_q  <= out_irq_d;
      out_rst_q  <= out_rst_d;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign control_value_o = out_ctrl_q;
  assign irq_raise_o     = out_irq_q;
  assign reset_request_o = out_rst_q;

endmodule

// File: hw/rtl/watchdog_timer_timed_unlock.sv
// ----------------------------------------------------------------------------
// watchdog_timer_timed_unlock: watchdog timer with timed unlock
// Top level with the configuration registers, the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per event: tuser selects tick, register
//   write, kick, interrupt acknowledge or reset; tdata carries the write
//   value and the two status flags. Each word yields one result word on the
//   master stream: the control register, an interrupt strobe and a reset
//   request. Clock frequencies are set through the APB port while idle; the
//   block does not enforce this. A result is registered and appears in the
//   cycle after its word is taken, and a word that does not restart the
//   timer is followed by the next one in the following cycle if the receiver
//   is ready. A word that restarts the timer with a valid prescale and nonzero
//   wdt clock holds tready low until the bit-serial timeout divider is done.
//   After reset the control register, timer and unlock window are cleared and
//   the clock frequencies return to 16 MHz and 128 kHz.
//   While the receiver stalls the result word holds and no new word is taken.
// ----------------------------------------------------------------------------
module watchdog_timer_timed_unlock #(
  parameter int unsigned CountWidth   = wdt_pkg::CountWidthDef,
  parameter int unsigned UnlockCycles = wdt_pkg::UnlockCyclesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: write_value[7:0], reset_flag_set[8], reset_by_watchdog[9], zeros
  input  logic [15:0] s_axis_tdata,
  // tuser: func[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: control_value[7:0], irq_raise[8], reset_request[9], zeros
  output logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wdt_pkg::*;

  logic [CpuFreqW-1:0] cpu_freq_q;
  logic [WdtFreqW-1:0] wdt_freq_q;
  logic                cfg_we;
  wdt_cmd_t            cmd;
  wdt_status_t         status;
  logic [7:0]          control_value;
  logic                irq_raise;
  logic                reset_request;

  // Configuration registers, one per word address.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_freq_q <= CpuFreqReset;
      wdt_freq_q <= WdtFreqReset;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        wdt_freq_q <= pwdata[WdtFreqW-1:0];
      end else begin
        cpu_freq_q <= pwdata[CpuFreqW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(wdt_freq_q) : cpu_freq_q;

  wdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  wdt_datapath #(
    .CountWidth   (CountWidth),
    .UnlockCycles (UnlockCycles)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cpu_freq_i          (cpu_freq_q),
    .wdt_freq_i          (wdt_freq_q),
    .func_i              (s_axis_tuser),
    .write_value_i       (s_axis_tdata[7:0]),
    .reset_flag_set_i    (s_axis_tdata[8]),
    .reset_by_watchdog_i (s_axis_tdata[9]),
    .m_ready_i           (m_axis_tready),
    .m_valid_o           (m_axis_tvalid),
    .control_value_o     (control_value),
    .irq_raise_o         (irq_raise),
    .reset_request_o     (reset_request)
  );

  assign m_axis_tdata = {6'b000000, reset_request, irq_raise, control_value};

endmodule

// File: hw/rtl/wdt_checker.sv
// ----------------------------------------------------------------------------
// wdt_checker: port level checks of the watchdog timer
// Watches the streams and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module wdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import wdt_pkg::*;

  // A taken word produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("no result after a taken word");

  // No word is taken while a result is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !(s_axis_tvalid && s_axis_tready))
    else $error("word taken while result stalled");

  // A raised interrupt leaves the interrupt flag set and no reset request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[BitIf] && !m_axis_tdata[9]))
    else $error("interrupt without flag or with reset request");

  // An ordinary reset clears the control register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_RESET) && !s_axis_tdata[9])
    |=> (m_axis_tdata[7:0] == 8'h00))
    else $error("control register not cleared by reset");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind watchdog_timer_timed_unlock wdt_checker u_wdt_checker (.*);

// File: test/watchdog_timer_timed_unlock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// watchdog_timer_timed_unlock_tb: self-checking bench for the watchdog timer
// Event words go in on the slave stream and every result word is compared,
// field by field, with an in-bench model of the control register, the
// timeout counter and the unlock window. The clock frequencies are changed
// over APB between phases. The stimulus is a directed part, then random
// unlock sequences and noise, with random idling on both streams.
// ----------------------------------------------------------------------------
module watchdog_timer_timed_unlock_tb;
  import wdt_pkg::*;

  localparam int unsigned CountW     = CountWidthDef;
  localparam logic [63:0] CountMax   = (64'd1 << CountW) - 64'd1;
  localparam logic [2:0]  AddrCpuHz  = 3'd0;
  localparam logic [2:0]  AddrOscHz  = 3'd4;
  // Highest code that the func field can carry; codes above reset are spare.
  localparam logic [2:0]  FuncTop    = 3'b111;
  localparam int          HoldCycles = 300;
  localparam int          IdleLimit  = 2000;
  localparam int          SettleWait = 60;

  localparam logic [7:0] MIf = 8'h01 << BitIf;
  localparam logic [7:0] MIe = 8'h01 << BitIe;
  localparam logic [7:0] MCe = 8'h01 << BitCe;
  localparam logic [7:0] MRe = 8'h01 << BitRe;

  typedef struct packed {
    logic [7:0] ctl;
    logic       irq;
    logic       rst;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  watchdog_timer_timed_unlock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // tdata: write_value[7:0], reset_flag_set[8], reset_by_watchdog[9], zeros
    .s_axis_tdata  (s_axis_tdata),
    // tuser: func[2:0]
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // tdata: control_value[7:0], irq_raise[8], reset_request[9], zeros
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock generation, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state of the watchdog and its clock settings.
  logic [7:0]        ctl_m;
  logic              run_m;
  logic [CountW-1:0] left_m;
  logic [2:0]        window_m;
  logic [31:0]       cpu_hz_m;
  logic [19:0]       osc_hz_m;

  status_t awaited_status[$];
  int      mismatches = 0;
  int      words_sent = 0;
  int      results_seen = 0;
  int      irq_seen = 0;
  int      rst_seen = 0;
  int      settings = 0;
  int      hold_left = 0;
  bit      quiet = 1'b0;

  // Timeout length for the current prescale and clock settings.
  function automatic logic [CountW-1:0] timeout_len();
    logic [3:0]  p;
    logic [63:0] prod;
    logic [63:0] d;
    p = {ctl_m[BitP3], ctl_m[2:0]};
    if (p > PrescaleMax || osc_hz_m == '0) return '0;
    prod = {32'd0, cpu_hz_m} << (p + ShiftBase);
    d = prod / {44'd0, osc_hz_m};
    if (d > CountMax) d = CountMax;
    return d[CountW-1:0];
  endfunction

  function automatic void restart_count();
    left_m = timeout_len();
    run_m  = (left_m != '0);
  endfunction

  function automatic void stop_count();
    run_m  = 1'b0;
    left_m = '0;
  endfunction

  // Works out the result word caused by one event word.
  function automatic status_t advance_watchdog(logic [2:0] fn, logic [7:0] wv,
                                               logic fs, logic bw);
    status_t    r;
    logic [7:0] old_v;
    logic [7:0] v;
    logic [7:0] kept;
    logic       open_w;
    r.irq = 1'b0;
    r.rst = 1'b0;
    case (fn)
      FUNC_TICK: begin
        if (window_m != '0) begin
          window_m = window_m - 3'd1;
          if (window_m == '0) ctl_m = ctl_m & ~MCe;
        end
        if (run_m) begin
          left_m = left_m - 1'b1;
          if (left_m == '0) begin
            run_m = 1'b0;
            if (ctl_m[BitIe] && !ctl_m[BitIf]) begin
              ctl_m = ctl_m | MIf;
              r.irq = 1'b1;
              restart_count();
            end else if (ctl_m[BitRe] || ctl_m[BitIf]) begin
              r.rst = 1'b1;
            end
          end
        end
      end
      FUNC_WRITE: begin
        old_v  = ctl_m;
        v      = wv;
        open_w = (window_m != '0);
        if (fs) v = v | MRe;
        if (open_w) begin
          v = v | MCe;
        end else begin
          // Locked: prescale is held and reset enable cannot be cleared.
          v = (v & ~PrescaleMask) | (old_v & PrescaleMask);
          if (old_v[BitRe]) v = v | MRe;
        end
        // Writing one to the interrupt flag clears it, zero keeps it.
        kept = v & ~MIf;
        if (!v[BitIf]) kept = kept | (old_v & MIf);
        ctl_m = kept;
        if (open_w) begin
          if (((v ^ old_v) & PrescaleMask) != '0) restart_count();
          if (old_v[BitRe] && !v[BitRe]) stop_count();
        end else if (v[BitCe] && v[BitRe]) begin
          window_m = 3'(UnlockCyclesDef);
        end
        if (((v & ~old_v) & (MRe | MIe)) != '0) restart_count();
      end
      FUNC_KICK: begin
        if (run_m) restart_count();
      end
      FUNC_ACK: begin
        ctl_m = ctl_m & ~(MIf | MIe);
        restart_count();
      end
      FUNC_RESET: begin
        stop_count();
        window_m = '0;
        if (bw) begin
          ctl_m = MRe;
          restart_count();
        end else begin
          ctl_m = '0;
        end
      end
      default: ;
    endcase
    r.ctl = ctl_m;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endtask

  // Result stream: check each accepted word, then decide on tready.
  always @(posedge clk_i) begin : result_check
    status_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[8]) irq_seen++;
      if (m_axis_tdata[9]) rst_seen++;
      if (awaited_status.size() == 0) begin
        report_mismatch("unexpected result word", '0, 32'(m_axis_tdata));
      end else begin
        want = awaited_status.pop_front();
        if (m_axis_tdata[7:0] != want.ctl)
          report_mismatch("control_value", 32'(want.ctl), 32'(m_axis_tdata[7:0]));
        if (m_axis_tdata[8] != want.irq)
          report_mismatch("irq_raise", 32'(want.irq), 32'(m_axis_tdata[8]));
        if (m_axis_tdata[9] != want.rst)
          report_mismatch("reset_request", 32'(want.rst), 32'(m_axis_tdata[9]));
      end
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 30);
    end
  end

  // Ends the run when nothing at all is accepted for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no word accepted for %0d cycles", IdleLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one event word, idling at random first, and predicts its result.
  task automatic send_word(input logic [2:0] fn, input logic [7:0] wv,
                           input logic fs, input logic bw);
    while (!quiet && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, bw, fs, wv};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_status.push_back(advance_watchdog(fn, wv, fs, bw));
    words_sent++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != want) report_mismatch("register read-back", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering words and waits until every result is in and the
  // divider has had time to finish.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic set_clocks(input logic [31:0] cpu, input logic [19:0] osc);
    drain_results();
    apb_write(AddrCpuHz, cpu);
    apb_write(AddrOscHz, {12'd0, osc});
    cpu_hz_m = cpu;
    osc_hz_m = osc;
    apb_read(AddrCpuHz, cpu);
    apb_read(AddrOscHz, {12'd0, osc});
    settings++;
  endtask

  // Mostly unlock sequences and ticks, with stray writes and spare codes.
  task automatic send_random_words(input int count);
    int         n;
    int         pick;
    int         gap;
    logic [7:0] wv;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      wv   = 8'($urandom);
      if (pick < 55) begin
        send_word(FUNC_TICK, wv, 1'($urandom), 1'($urandom));
      end else if (pick < 62) begin
        send_word(FUNC_KICK, wv, 1'($urandom), 1'($urandom));
      end else if (pick < 67) begin
        send_word(FUNC_ACK, wv, 1'($urandom), 1'($urandom));
      end else if (pick < 71) begin
        send_word(FUNC_RESET, wv, 1'($urandom), 1'($urandom));
      end else if (pick < 74) begin
        send_word(3'($urandom_range(FUNC_RESET + 1, FuncTop)), wv, 1'($urandom),
                  1'($urandom));
      end else if (pick < 86) begin
        send_word(FUNC_WRITE, wv, ($urandom_range(0, 4) == 0), 1'($urandom));
      end else begin
        // Open the window, let a few ticks pass, then the timed write.
        send_word(FUNC_WRITE, wv | MCe | MRe, ($urandom_range(0, 4) == 0),
                  1'($urandom));
        gap = $urandom_range(0, UnlockCyclesDef);
        repeat (gap) begin
          send_word(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
          n++;
        end
        send_word(FUNC_WRITE, 8'($urandom), ($urandom_range(0, 4) == 0),
                  1'($urandom));
        n++;
      end
      n++;
    end
  endtask

  task automatic test_reset_values();
    apb_read(AddrCpuHz, CpuFreqReset);
    apb_read(AddrOscHz, {12'd0, WdtFreqReset});
  endtask

  // Every event kind, the lock rules, the window and both timeout branches.
  task automatic test_directed();
    set_clocks(32'd125, 20'd128000);
    send_word(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
    send_word(FUNC_WRITE, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_WRITE, 8'hFF, 1'b0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_WRITE, 8'h21, 1'b0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_WRITE, 8'h00, 1'b1, 1'b0);
    send_word(FUNC_WRITE, 8'h18, 1'b0, 1'b0);
    send_word(FUNC_WRITE, 8'h2F, 1'b0, 1'b0);
    send_word(FUNC_KICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_ACK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_RESET, 8'h00, 1'b0, 1'b1);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    send_word(FUNC_RESET, 8'hFF, 1'b1, 1'b0);
    send_word(3'(FUNC_RESET + 1), 8'hA5, 1'b1, 1'b1);
    send_word(FuncTop, 8'h5A, 1'b0, 1'b1);
    send_word(FUNC_WRITE, 8'h80, 1'b0, 1'b0);
  endtask

  // Highest clock ratio, zero oscillator frequency and the slowest CPU clock.
  task automatic test_clock_extremes();
    set_clocks(32'hFFFF_FFFF, 20'd1);
    send_word(FUNC_WRITE, 8'h18, 1'b0, 1'b0);
    send_word(FUNC_WRITE, 8'h29, 1'b0, 1'b0);
    send_word(FUNC_KICK, 8'h00, 1'b0, 1'b0);
    set_clocks(32'd1000, 20'd0);
    send_word(FUNC_WRITE, 8'h48, 1'b0, 1'b0);
    set_clocks(32'd1, 20'hF_FFFF);
    send_word(FUNC_RESET, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_random_settings();
    set_clocks(32'd125, 20'd128000);
    send_random_words(880);
    set_clocks(32'($urandom_range(1, 400)), 20'($urandom_range(100000, 1048575)));
    send_random_words(300);
    set_clocks(CpuFreqReset, WdtFreqReset);
    send_random_words(150);
    set_clocks(32'hFFFF_FFFF, 20'hF_FFFF);
    send_random_words(100);
  endtask

  // The receiver holds off while words keep coming, so the input stalls.
  task automatic test_backpressure();
    set_clocks(32'd60, 20'd128000);
    hold_left = HoldCycles;
    send_random_words(40);
  endtask

  // A long stretch with neither side idling.
  task automatic test_full_rate();
    set_clocks(32'd125, 20'd128000);
    quiet = 1'b1;
    send_random_words(400);
    drain_results();
    quiet = 1'b0;
  endtask

  initial begin
    ctl_m    = '0;
    run_m    = 1'b0;
    left_m   = '0;
    window_m = '0;
    cpu_hz_m = CpuFreqReset;
    osc_hz_m = WdtFreqReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed();
    test_clock_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    drain_results();

    $display("covered %0d event words over %0d clock settings, including a %0d-cycle stall",
             words_sent, settings, HoldCycles);
    $display("checked %0d result words: %0d interrupts, %0d reset requests, %0d mismatches",
             results_seen, irq_seen, rst_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/wdt_pkg.sv
hw/rtl/wdt_ctrl.sv
hw/rtl/wdt_datapath.sv
hw/rtl/watchdog_timer_timed_unlock.sv
hw/rtl/wdt_checker.sv
test/watchdog_timer_timed_unlock_tb.sv
